// ===== rtl/core/pid_position_regulator_macros.svh =====
// ----------------------------------------------------------------------------
// pid_position_regulator_macros
// Assertion macros shared by the regulator RTL.
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_REGULATOR_MACROS_SVH
`define PID_POSITION_REGULATOR_MACROS_SVH

// Check that a condition implies another in the same cycle
`define PIDR_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pidr assertion failed");

// Check that a condition implies another in the next cycle
`define PIDR_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pidr assertion failed");

`endif

// ===== rtl/core/pidr_pkg.sv =====
// ----------------------------------------------------------------------------
// pidr_pkg
// Types and constants of the position PID regulator.
// ----------------------------------------------------------------------------
package pidr_pkg;

    localparam int AluW = 56;   // operand / result width of the shared unit
    localparam int DivW = 20;   // divisor and multiplier width

    // Reciprocals of the reference divisors, scaled by 2^30; exact over the
    // whole 9-bit reference range
    localparam logic [AluW-1:0] RECIP_255 = 56'd4210753;
    localparam logic [AluW-1:0] RECIP_100 = 56'd10737419;

    // Configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [2:0] REG_SAMPLE_RATE = 3'd3;
    localparam logic [2:0] REG_OUT_DIV     = 3'd4;
    localparam logic [2:0] REG_DEADBAND    = 3'd5;
    localparam logic [2:0] REG_DUTY_LIMIT  = 3'd6;

    // Request kinds
    localparam logic REQ_SET_REF = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic            start;
        alu_op_t         op;
        logic [AluW-1:0] a;     // multiplicand or left-aligned dividend
        logic [DivW-1:0] b;     // multiplier or divisor
        logic [5:0]      cnt;   // number of bit steps
    } alu_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [AluW-1:0] res;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REF_DIV,
        ST_MUL_P,
        ST_MUL_I,
        ST_DIV_I,
        ST_MUL_DF,
        ST_MUL_D,
        ST_DIV_U,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/pidr_alu.sv =====
// ----------------------------------------------------------------------------
// pidr_alu
// Shared bit-serial unsigned multiplier and restoring divider.
// ----------------------------------------------------------------------------
module pidr_alu
    import pidr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    alu_op_t         op_reg, op_next;
    logic [AluW-1:0] a_reg, a_next;
    logic [AluW-1:0] acc_reg, acc_next;
    logic [DivW-1:0] b_reg, b_next;
    logic [DivW-1:0] rem_reg, rem_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [DivW:0]   shifted;
    logic [DivW:0]   diff;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk) begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    // Advance one bit step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg, acc_reg[AluW-1]};
        diff      = shifted - {1'b0, b_reg};
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                op_next   = req.op;
                b_next    = req.b;
                cnt_next  = req.cnt;
                rem_next  = '0;
                if (req.op == ALU_MUL) begin
                    a_next   = req.a;
                    acc_next = '0;
                end else begin
                    acc_next = req.a;
                end
            end
        end else begin
            case (op_reg)
                ALU_MUL:
                begin
                    if (b_reg[0]) begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[AluW-2:0], 1'b0};
                    b_next = {1'b0, b_reg[DivW-1:1]};
                end
                ALU_DIV:
                begin
                    if (!diff[DivW]) begin
                        rem_next = diff[DivW-1:0];
                        acc_next = {acc_reg[AluW-2:0], 1'b1};
                    end else begin
                        rem_next = shifted[DivW-1:0];
                        acc_next = {acc_reg[AluW-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

// ===== rtl/core/pid_position_regulator.sv =====
// ----------------------------------------------------------------------------
// pid_position_regulator
// Motor position PID regulator with one shared serial multiply/divide unit.
// ----------------------------------------------------------------------------
// A sample tick runs four multiplies of 16 or 19 bit steps and two divides
// of 48 and 56 bit steps, in turn on the one bit-per-cycle unit in pidr_alu,
// and then loads the output register; a zero sample rate skips the integral
// divide. A stalled result holds the block in that last state until the
// output register is free. A reference request runs one 20-step reciprocal
// multiply and gives no result. The block takes one request at a time and is
// ready again once it is back in idle; a finished result waits in the output
// register while the next request is accepted.
module pid_position_regulator
    import pidr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // ref_value[8:0], measured_position[24:9]
    input  logic [1:0]  s_tuser,   // req_type[0], ref_is_slider[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // motor_reverse[0], duty[16:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    `include "pid_position_regulator_macros.svh"

    // Configuration registers
    logic [15:0] kp_reg, ki_reg, kd_reg, duty_lim_reg;
    logic [19:0] rate_reg;
    logic [9:0]  div_reg, dead_reg;

    // Control and state
    state_t             state_reg, state_next;
    logic               issued_reg, issued_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] target_reg, target_next;
    logic signed [17:0] last_reg, last_next;
    logic signed [31:0] sum_reg, sum_next;

    // Datapath registers
    logic signed [17:0] e_reg, e_next;
    logic signed [18:0] d_reg, d_next;
    logic signed [56:0] acc_reg, acc_next;
    logic [AluW-1:0]    tmp_reg, tmp_next;
    logic               tmp_neg_reg, tmp_neg_next;
    logic               ref_neg_reg, ref_neg_next;
    logic               ref_sl_reg, ref_sl_next;
    logic               rev_reg, rev_next;
    logic [15:0]        duty_reg, duty_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic               accept;
    logic signed [8:0]  in_ref;
    logic signed [15:0] in_meas;
    logic signed [17:0] e_in;
    logic [8:0]         ref_mag;
    logic [19:0]        ref_prod;
    logic [17:0]        e_mag;
    logic [18:0]        d_mag;
    logic [31:0]        sum_mag;
    logic [AluW-1:0]    acc_mag;
    logic signed [56:0] res_s;
    logic signed [56:0] res_neg;
    logic signed [15:0] q_s;
    logic [17:0]        ae;
    logic signed [33:0] sum_wide;
    logic [56:0]        u_mag;

    pidr_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_ref    = s_tdata[8:0];
    assign in_meas   = s_tdata[24:9];
    assign e_in      = 18'(target_reg) - 18'(in_meas);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kp_reg       <= 16'd50;
            ki_reg       <= 16'd10;
            kd_reg       <= 16'd1000;
            rate_reg     <= 20'd50000;
            div_reg      <= 10'd10;
            dead_reg     <= 10'd20;
            duty_lim_reg <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROP_GAIN:   kp_reg       <= cfg_data[15:0];
                REG_INTEG_GAIN:  ki_reg       <= cfg_data[15:0];
                REG_DERIV_GAIN:  kd_reg       <= cfg_data[15:0];
                REG_SAMPLE_RATE: rate_reg     <= cfg_data;
                REG_OUT_DIV:     div_reg      <= cfg_data[9:0];
                REG_DEADBAND:    dead_reg     <= cfg_data[9:0];
                REG_DUTY_LIMIT:  duty_lim_reg <= cfg_data[15:0];
                default:         kp_reg       <= kp_reg;
            endcase
        end
    end

    // Hold control and regulator state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            target_reg  <= 16'sd1400;
            last_reg    <= '0;
            sum_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
            target_reg  <= target_next;
            last_reg    <= last_next;
            sum_reg     <= sum_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk) begin
        e_reg       <= e_next;
        d_reg       <= d_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        tmp_neg_reg <= tmp_neg_next;
        ref_neg_reg <= ref_neg_next;
        ref_sl_reg  <= ref_sl_next;
        rev_reg     <= rev_next;
        duty_reg    <= duty_next;
    end

    // Magnitudes, the reference product, signed views of the unit result and the widened integral sum
    always_comb begin
        ref_mag  = in_ref[8] ? 9'(-in_ref) : 9'(in_ref);
        ref_prod = s_tuser[1] ? 20'(ref_mag) * 20'd2800 : 20'(ref_mag) * 20'd1400;
        e_mag    = e_reg[17] ? 18'(-e_reg) : 18'(e_reg);
        d_mag    = d_reg[18] ? 19'(-d_reg) : 19'(d_reg);
        sum_mag  = sum_reg[31] ? 32'(-sum_reg) : 32'(sum_reg);
        acc_mag  = acc_reg[56] ? AluW'(-acc_reg) : AluW'(acc_reg);
        res_s    = $signed({1'b0, alu_rsp.res});
        res_neg  = -res_s;
        // Quotient of the reciprocal multiply sits above the 30 fraction bits
        q_s      = ref_neg_reg ? 16'(-alu_rsp.res[45:30]) : 16'(alu_rsp.res[45:30]);
        ae       = e_reg[17] ? 18'(-e_reg) : 18'(e_reg);
        sum_wide = 34'(sum_reg) + 34'(e_reg);
        u_mag    = acc_reg[56] ? 57'(-acc_reg) : 57'(acc_reg);
    end

    // Sequence the shared unit through the PID terms
    always_comb begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        m_valid_next = m_valid_reg;
        target_next  = target_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        e_next       = e_reg;
        d_next       = d_reg;
        acc_next     = acc_reg;
        tmp_next     = tmp_reg;
        tmp_neg_next = tmp_neg_reg;
        ref_neg_next = ref_neg_reg;
        ref_sl_next  = ref_sl_reg;
        rev_next     = rev_reg;
        duty_next    = duty_reg;
        alu_req      = '0;

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                issued_next = 1'b0;
                if (accept) begin
                    if (s_tuser[0] == REQ_SET_REF) begin
                        ref_neg_next = in_ref[8];
                        ref_sl_next  = s_tuser[1];
                        tmp_next     = AluW'(ref_prod);
                        state_next   = ST_REF_DIV;
                    end else begin
                        e_next     = e_in;
                        d_next     = 19'(e_in) - 19'(last_reg);
                        acc_next   = '0;
                        state_next = ST_MUL_P;
                    end
                end
            end
            ST_REF_DIV:
            begin
                // Scale the reference by the reciprocal of its divisor
                alu_req.op  = ALU_MUL;
                alu_req.a   = ref_sl_reg ? RECIP_255 : RECIP_100;
                alu_req.b   = tmp_reg[DivW-1:0];
                alu_req.cnt = 6'd20;
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (alu_rsp.done) begin
                    issued_next = 1'b0;
                    target_next = ref_sl_reg ? q_s : 16'sd1400 + q_s;
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL_P:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.a   = AluW'(e_mag);
                alu_req.b   = DivW'(kp_reg);
                alu_req.cnt = 6'd16;
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (alu_rsp.done) begin
                    issued_next = 1'b0;
                    acc_next    = e_reg[17] ? res_neg : res_s;
                    state_next  = ST_MUL_I;
                end
            end
            ST_MUL_I:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.a   = AluW'(sum_mag);
                alu_req.b   = DivW'(ki_reg);
                alu_req.cnt = 6'd16;
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (alu_rsp.done) begin
                    issued_next  = 1'b0;
                    tmp_next     = {alu_rsp.res[47:0], 8'd0};
                    tmp_neg_next = sum_reg[31];
                    state_next   = (rate_reg == '0) ? ST_MUL_DF : ST_DIV_I;
                end
            end
            ST_DIV_I:
            begin
                alu_req.op  = ALU_DIV;
                alu_req.a   = tmp_reg;
                alu_req.b   = rate_reg;
                alu_req.cnt = 6'd48;
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (alu_rsp.done) begin
                    issued_next = 1'b0;
                    acc_next    = acc_reg + (tmp_neg_reg ? res_neg : res_s);
                    state_next  = ST_MUL_DF;
                end
            end
            ST_MUL_DF:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.a   = AluW'(rate_reg);
                alu_req.b   = DivW'(kd_reg);
                alu_req.cnt = 6'd16;
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (alu_rsp.done) begin
                    issued_next = 1'b0;
                    tmp_next    = alu_rsp.res;
                    state_next  = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.a   = tmp_reg;
                alu_req.b   = DivW'(d_mag);
                alu_req.cnt = 6'd19;
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (alu_rsp.done) begin
                    issued_next = 1'b0;
                    acc_next    = acc_reg + (d_reg[18] ? res_neg : res_s);
                    state_next  = ST_DIV_U;
                end
            end
            ST_DIV_U:
            begin
                alu_req.op  = ALU_DIV;
                alu_req.a   = acc_mag;
                alu_req.b   = (div_reg == '0) ? 20'd1 : DivW'(div_reg);
                alu_req.cnt = 6'd56;
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (alu_rsp.done) begin
                    issued_next = 1'b0;
                    acc_next    = acc_reg[56] ? res_neg : res_s;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    last_next    = e_reg;
                    state_next   = ST_IDLE;
                    if (ae < 18'(dead_reg)) begin
                        rev_next  = 1'b1;
                        duty_next = '0;
                    end else begin
                        rev_next  = !(!acc_reg[56] && (acc_reg != '0));
                        duty_next = (u_mag > 57'(duty_lim_reg)) ? duty_lim_reg : u_mag[15:0];
                        if (acc_reg < $signed({41'd0, duty_lim_reg})) begin
                            if (sum_wide > 34'sh0_7FFF_FFFF) begin
                                sum_next = 32'sh7FFF_FFFF;
                            end else if (sum_wide < -34'sh0_8000_0000) begin
                                sum_next = 32'sh8000_0000;
                            end else begin
                                sum_next = sum_wide[31:0];
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, duty_reg, rev_reg};

    // Sequencer and shared unit agree on idle
    `PIDR_ASSERT_IMP(a_ready_unit_idle, s_tready, !alu_rsp.busy)
    `PIDR_ASSERT_IMP(a_done_while_busy_state, alu_rsp.done, state_reg != ST_IDLE)
    `PIDR_ASSERT_NXT(a_busy_after_accept, accept, !s_tready)

endmodule
